FILE: hw/rtl/u8sd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_pkg
// Byte tags, field widths and the decoder state type for the UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CP_W    = 21;
   localparam int unsigned LEN_W   = 3;
   localparam int unsigned REM_W   = 2;

   localparam logic [CP_W-1:0]   CP_REPLACEMENT = 21'h00FFFD;
   localparam logic [BYTE_W-1:0] CONT_TAG       = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_TAG      = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_TAG      = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_TAG      = 8'hF0;

   localparam logic [LEN_W-1:0]  LEN_1 = 3'd1;
   localparam logic [LEN_W-1:0]  LEN_2 = 3'd2;
   localparam logic [LEN_W-1:0]  LEN_3 = 3'd3;
   localparam logic [LEN_W-1:0]  LEN_4 = 3'd4;

   // Open-sequence context carried between bytes
   typedef struct packed {
      logic [REM_W-1:0] remaining;
      logic [CP_W-1:0]  acc;
      logic [LEN_W-1:0] total;
      logic             bad;
   } seq_state_type;

endpackage : u8sd_pkg
`default_nettype wire

FILE: hw/rtl/utf8_stream_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial UTF-8 decoder: one byte per item in, one code point per
// completed sequence out, with a malformed mark for bad lead or
// continuation bytes.
//
//   Channel   Ports                                     Dir   Width
//   req       req_valid/req_ready, req_in_byte          in    8
//   rsp       rsp_valid/rsp_ready, rsp_code_point,      out   21
//             rsp_seq_length, rsp_malformed                   3, 1
//
// One byte is taken per cycle while req_ready is high; a result appears in
// the output register the cycle after the byte that ends its sequence.
// req_ready is low only while the output register holds a result that the
// sink does not take in that cycle.
// Synchronous active-high reset drops any open sequence and the pending result.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [u8sd_pkg::BYTE_W-1:0] req_in_byte,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [u8sd_pkg::CP_W-1:0]       rsp_code_point,
   output logic [u8sd_pkg::LEN_W-1:0]      rsp_seq_length,
   output logic                            rsp_malformed
);
   import u8sd_pkg::*;

   seq_state_type    seq_ff, seq_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CP_W-1:0]  cp_ff, cp_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             mal_ff, mal_in;

   logic             accept;
   logic             emit;
   logic             cont_bad;
   logic [CP_W-1:0]  acc_shift;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign cont_bad  = (req_in_byte & 8'hC0) != CONT_TAG;
   assign acc_shift = {seq_ff.acc[CP_W-7:0], req_in_byte[5:0]};

   always_comb begin
      seq_in = seq_ff;
      emit   = 1'b0;
      cp_in  = cp_ff;
      len_in = len_ff;
      mal_in = mal_ff;
      if (seq_ff.remaining == '0) begin
         if (!req_in_byte[7]) begin
            emit   = 1'b1;
            cp_in  = {{(CP_W-BYTE_W){1'b0}}, req_in_byte};
            len_in = LEN_1;
            mal_in = 1'b0;
         end else if ((req_in_byte & 8'hF8) == LEAD4_TAG) begin
            seq_in.acc       = {{(CP_W-3){1'b0}}, req_in_byte[2:0]};
            seq_in.total     = LEN_4;
            seq_in.remaining = 2'd3;
            seq_in.bad       = 1'b0;
         end else if ((req_in_byte & 8'hF0) == LEAD3_TAG) begin
            seq_in.acc       = {{(CP_W-4){1'b0}}, req_in_byte[3:0]};
            seq_in.total     = LEN_3;
            seq_in.remaining = 2'd2;
            seq_in.bad       = 1'b0;
         end else if ((req_in_byte & 8'hE0) == LEAD2_TAG) begin
            seq_in.acc       = {{(CP_W-5){1'b0}}, req_in_byte[4:0]};
            seq_in.total     = LEN_2;
            seq_in.remaining = 2'd1;
            seq_in.bad       = 1'b0;
         end else begin
            emit   = 1'b1;
            cp_in  = CP_REPLACEMENT;
            len_in = LEN_1;
            mal_in = 1'b1;
         end
      end else begin
         // any byte counts towards the announced length, good or not
         seq_in.acc       = acc_shift;
         seq_in.bad       = seq_ff.bad || cont_bad;
         seq_in.remaining = seq_ff.remaining - 2'd1;
         if (seq_ff.remaining == 2'd1) begin
            emit   = 1'b1;
            len_in = seq_ff.total;
            mal_in = seq_in.bad;
            cp_in  = seq_in.bad ? CP_REPLACEMENT : acc_shift;
            seq_in = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            seq_ff <= seq_in;
         end
      end
   end

   // result payload: load only with a new result
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         cp_ff  <= cp_in;
         len_ff <= len_in;
         mal_ff <= mal_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_point = cp_ff;
   assign rsp_seq_length = len_ff;
   assign rsp_malformed  = mal_ff;

   a_ascii_next: assert property (@(posedge clock) disable iff (reset)
      (accept && seq_ff.remaining == '0 && !req_in_byte[7]) |=> rsp_valid_ff)
      else $error("ASCII byte did not produce a result");

   a_mal_cp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && mal_ff) |-> (cp_ff == CP_REPLACEMENT))
      else $error("malformed result without replacement code point");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (len_ff == LEN_1 || len_ff == LEN_2 ||
                        len_ff == LEN_3 || len_ff == LEN_4))
      else $error("result length out of range");

   a_one_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !mal_ff && len_ff == LEN_1) |-> (cp_ff[CP_W-1:7] == '0))
      else $error("one-byte result above 0x7F");

endmodule : utf8_stream_decoder
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 stream decoder. A short directed byte
// stream covers the edge cases and is followed by random sequences, mostly
// well-formed and partly corrupted. A scoreboard decodes every accepted byte
// on its own and compares each result with the oldest code point it expects.
// Bursty input and a stalling sink exercise the handshake.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [u8sd_pkg::CP_W-1:0]  code_point;
   logic [u8sd_pkg::LEN_W-1:0] seq_length;
   logic                       malformed;
} decoded_cp_type;

class utf8_scoreboard;
   u8sd_pkg::seq_state_type open_seq;
   decoded_cp_type          cp_due_q[$];

   function new();
      open_seq = '0;
   endfunction

   function void start_sequence(logic [u8sd_pkg::CP_W-1:0] payload,
                                logic [u8sd_pkg::LEN_W-1:0] total);
      open_seq.acc       = payload;
      open_seq.total     = total;
      open_seq.remaining = u8sd_pkg::REM_W'(total - 1);
      open_seq.bad       = 1'b0;
   endfunction

   // Decode one accepted byte and queue the code point it completes, if any
   function void note_byte(logic [u8sd_pkg::BYTE_W-1:0] b);
      decoded_cp_type cp;
      if (open_seq.remaining == '0) begin
         if (b[7] == 1'b0) begin
            cp = '{code_point: u8sd_pkg::CP_W'(b), seq_length: u8sd_pkg::LEN_1,
                   malformed: 1'b0};
            cp_due_q.push_back(cp);
         end else if (b[7:3] == u8sd_pkg::LEAD4_TAG[7:3]) begin
            start_sequence(u8sd_pkg::CP_W'(b[2:0]), u8sd_pkg::LEN_4);
         end else if (b[7:4] == u8sd_pkg::LEAD3_TAG[7:4]) begin
            start_sequence(u8sd_pkg::CP_W'(b[3:0]), u8sd_pkg::LEN_3);
         end else if (b[7:5] == u8sd_pkg::LEAD2_TAG[7:5]) begin
            start_sequence(u8sd_pkg::CP_W'(b[4:0]), u8sd_pkg::LEN_2);
         end else begin
            cp = '{code_point: u8sd_pkg::CP_REPLACEMENT, seq_length: u8sd_pkg::LEN_1,
                   malformed: 1'b1};
            cp_due_q.push_back(cp);
         end
         return;
      end
      // Any byte inside an open sequence is consumed, lead-like or not
      if (b[7:6] != u8sd_pkg::CONT_TAG[7:6])
         open_seq.bad = 1'b1;
      open_seq.acc       = {open_seq.acc[u8sd_pkg::CP_W-7:0], b[5:0]};
      open_seq.remaining = open_seq.remaining - 1'b1;
      if (open_seq.remaining != '0)
         return;
      if (open_seq.bad)
         cp = '{code_point: u8sd_pkg::CP_REPLACEMENT, seq_length: open_seq.total,
                malformed: 1'b1};
      else
         cp = '{code_point: open_seq.acc, seq_length: open_seq.total,
                malformed: 1'b0};
      cp_due_q.push_back(cp);
      open_seq = '0;
   endfunction

   // Return an empty string when the result matches the oldest expectation
   function string check_result(decoded_cp_type got);
      decoded_cp_type want;
      string          diff;
      if (cp_due_q.size() == 0)
         return $sformatf("unexpected result cp=%h len=%0d mal=%b",
                          got.code_point, got.seq_length, got.malformed);
      want = cp_due_q.pop_front();
      diff = "";
      if (got.code_point != want.code_point)
         diff = {diff, $sformatf(" code_point %h/%h", got.code_point, want.code_point)};
      if (got.seq_length != want.seq_length)
         diff = {diff, $sformatf(" seq_length %0d/%0d", got.seq_length, want.seq_length)};
      if (got.malformed != want.malformed)
         diff = {diff, $sformatf(" malformed %b/%b", got.malformed, want.malformed)};
      if (diff != "")
         diff = {"got/want:", diff};
      return diff;
   endfunction

   function int unsigned pending();
      return cp_due_q.size();
   endfunction
endclass

module tb_top;
   import u8sd_pkg::*;

   typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_MASK, READY_SPARSE}
      stall_mode_type;

   localparam int unsigned STREAM_BYTES = 1750;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic [BYTE_W-1:0]   req_in_byte = '0;
   logic                rsp_ready   = 1'b0;
   logic                req_ready;
   logic                rsp_valid;
   logic [CP_W-1:0]     rsp_code_point;
   logic [LEN_W-1:0]    rsp_seq_length;
   logic                rsp_malformed;

   utf8_scoreboard      decode_sb;
   logic [BYTE_W-1:0]   stim_q[$];
   int unsigned         fail_count = 0;
   stall_mode_type      stall_mode = READY_ALWAYS;
   logic [7:0]          stall_mask = 8'hFF;
   logic [6:0]          phase_cnt  = '0;

   utf8_stream_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_seq_length (rsp_seq_length),
      .rsp_malformed  (rsp_malformed)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      fail_count++;
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [BYTE_W-1:0] random_cont();
      return {CONT_TAG[7:6], 6'($urandom_range(0, 63))};
   endfunction

   // Any byte that is not a continuation byte
   function automatic logic [BYTE_W-1:0] random_non_cont();
      logic [BYTE_W-1:0] b;
      b = 8'($urandom_range(0, 255));
      while (b[7:6] == CONT_TAG[7:6])
         b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   task automatic queue_sequence(input int unsigned len, input bit corrupt);
      logic [BYTE_W-1:0] seq[4];
      int unsigned       bad_pos;
      case (len)
         1:       seq[0] = 8'($urandom_range(0, 127));
         2:       seq[0] = {LEAD2_TAG[7:5], 5'($urandom_range(0, 31))};
         3:       seq[0] = {LEAD3_TAG[7:4], 4'($urandom_range(0, 15))};
         default: seq[0] = {LEAD4_TAG[7:3], 3'($urandom_range(0, 7))};
      endcase
      for (int i = 1; i < len; i++)
         seq[i] = random_cont();
      if (corrupt && len > 1) begin
         bad_pos = $urandom_range(1, len - 1);
         seq[bad_pos] = random_non_cont();
      end
      for (int i = 0; i < len; i++)
         stim_q.push_back(seq[i]);
   endtask

   task automatic build_random_stream();
      int unsigned pick;
      while (stim_q.size() < STREAM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)
            queue_sequence($urandom_range(1, 4), 1'b0);
         else if (pick < 70)
            queue_sequence($urandom_range(2, 4), 1'b1);
         else if (pick < 80)
            stim_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                  : 8'($urandom_range(8'hF8, 8'hFF)));
         else
            stim_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // Bursts of back-to-back items with random gaps between them
   task automatic feed_stream();
      int unsigned burst;
      int unsigned gap;
      while (stim_q.size() != 0) begin
         burst = $urandom_range(1, 60);
         for (int i = 0; i < burst && stim_q.size() != 0; i++)
            send_byte(stim_q.pop_front());
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   // Sink stall pattern, re-chosen each time phase_cnt wraps to zero
   always @(posedge clock) begin
      phase_cnt <= phase_cnt + 1'b1;
      if (phase_cnt == '0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_mask <= 8'($urandom_range(1, 255));
      end
      case (stall_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
         READY_MASK:   rsp_ready <= stall_mask[phase_cnt[2:0]];
         default:      rsp_ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   always @(posedge clock) begin
      string msg;
      if (!reset) begin
         if (req_valid && req_ready)
            decode_sb.note_byte(req_in_byte);
         if (rsp_valid && rsp_ready) begin
            msg = decode_sb.check_result('{code_point: rsp_code_point,
                                           seq_length: rsp_seq_length,
                                           malformed:  rsp_malformed});
            if (msg != "")
               report_mismatch(msg);
         end
      end
   end

   initial begin
      decode_sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ASCII extremes, invalid leads, each length, the 21-bit maximum,
      // an overlong form, and bad continuations that are plain or lead-like
      stim_q = {8'h00, 8'h7F, 8'h80, 8'hFF, 8'hF8,
                8'hC2, 8'hA9,
                8'hE2, 8'h82, 8'hAC,
                8'hF7, 8'hBF, 8'hBF, 8'hBF,
                8'hC3, 8'h41,
                8'hE1, 8'hF0, 8'h80,
                8'hF4, 8'h8F, 8'hBF, 8'h7F,
                8'hC0, 8'h80};
      build_random_stream();
      feed_stream();

      while (decode_sb.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #5000000;
      $display("Verification failed");
      $finish;
   end

endmodule
